### rtl/core/pts_pkg.sv
package pts_pkg;

    localparam int NUM_PRIORITIES = 32;
    localparam int DELAY_WIDTH    = 32;
    localparam int SLOT_W         = $clog2(NUM_PRIORITIES);
    localparam int LOCK_W         = 8;
    localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

    typedef enum logic [2:0] {
        K_TICK   = 3'd0,
        K_DELAY  = 3'd1,
        K_READY  = 3'd2,
        K_LOCK   = 3'd3,
        K_UNLOCK = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_FINISH,
        S_OUT
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                   tick;
        logic                   park;
        logic                   wake;
        logic [SLOT_W-1:0]      target;
        logic [DELAY_WIDTH-1:0] delay;
    } cell_ctrl_t;

    // priority search token passed down the chain
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } scan_t;

endpackage

### rtl/core/pts_req_if.sv
interface pts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  task_index;
    logic [31:0] delay_ticks;

    modport source (output valid, output kind, output task_index, output delay_ticks,
                    input ready);
    modport sink   (input valid, input kind, input task_index, input delay_ticks,
                    output ready);
endinterface

### rtl/core/pts_rsp_if.sv
interface pts_rsp_if;
    logic       valid;
    logic       ready;
    logic       any_ready;
    logic [4:0] chosen_task;
    logic       switch_request;
    logic [4:0] running_task;
    logic [7:0] lock_depth;

    modport source (output valid, output any_ready, output chosen_task,
                    output switch_request, output running_task, output lock_depth,
                    input ready);
    modport sink   (input valid, input any_ready, input chosen_task,
                    input switch_request, input running_task, input lock_depth,
                    output ready);
endinterface

### rtl/core/priority_task_scheduler_with_delays_top.sv
// Priority task scheduler with tick delays, one task per priority slot
// (slot 0 is the highest priority).
//
// Channels: req carries one event (kind, task_index, delay_ticks); rsp
// returns one status per event (any_ready, chosen_task, switch_request,
// running_task, lock_depth). Both use valid/ready; a request moves on a
// clock edge where both are high.
//
// Each slot lives in a cell holding its ready bit, waiting bit and delay
// counter. An event is applied to all cells at once in the apply state
// (ticks count every waiting cell down in parallel), then a search token
// ripples down the chain of cells, one cell per cycle, to find the lowest
// ready slot. A request passes the apply state, the scan states and the
// finish state, where the decision is registered; the result is then held
// in the out state. One request at a time: a new request is taken only in
// the idle state, after the result has been taken.
//
// Reset: ready and waiting sets cleared, running task 0, lock count 0;
// delay counters hold garbage until a delay loads them.
// Stall: the result is held in registers until rsp.ready; req.ready stays
// low until the result has been taken.
module priority_task_scheduler_with_delays_top (
    input  logic       clk,
    input  logic       rst_n,
    pts_req_if.sink    req,
    pts_rsp_if.source  rsp
);
    import pts_pkg::*;

    cell_ctrl_t ctrl;
    // chain[i] feeds cell i; chain[NUM_PRIORITIES] is the search result
    scan_t      chain [NUM_PRIORITIES+1];

    assign chain[0] = '0;

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .ctrl     (ctrl),
        .scan_res (chain[NUM_PRIORITIES])
    );

    for (genvar i = 0; i < NUM_PRIORITIES; i++)
    begin : g_cell
        pts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .slot_id  (SLOT_W'(i)),
            .ctrl     (ctrl),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1])
        );
    end

endmodule

### rtl/core/pts_cell.sv
module pts_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pts_pkg::SLOT_W-1:0] slot_id,
    input  pts_pkg::cell_ctrl_t       ctrl,
    input  pts_pkg::scan_t            scan_in,
    output pts_pkg::scan_t            scan_out
);
    import pts_pkg::*;

    logic                   ready_reg, ready_next;
    logic                   wait_reg, wait_next;
    logic [DELAY_WIDTH-1:0] cnt_reg, cnt_next;
    scan_t                  scan_reg, scan_next;
    logic                   hit;

    assign hit = (ctrl.target == slot_id);

    always_comb
    begin
        ready_next = ready_reg;
        wait_next  = wait_reg;
        cnt_next   = cnt_reg;
        if (ctrl.tick && wait_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DELAY_WIDTH'(1))
            begin
                wait_next  = 1'b0;
                ready_next = 1'b1;
            end
        end
        if (ctrl.park && hit)
        begin
            cnt_next   = ctrl.delay;
            wait_next  = 1'b1;
            ready_next = 1'b0;
        end
        if (ctrl.wake && hit)
        begin
            ready_next = 1'b1;
        end
        // lowest ready slot wins: keep an upstream hit
        scan_next.found = scan_in.found | ready_reg;
        scan_next.idx   = scan_in.found ? scan_in.idx : slot_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            wait_reg  <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            ready_reg <= ready_next;
            wait_reg  <= wait_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
    end

    assign scan_out = scan_reg;

endmodule

### rtl/core/pts_ctrl.sv
module pts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    pts_req_if.sink             req,
    pts_rsp_if.source           rsp,
    output pts_pkg::cell_ctrl_t ctrl,
    input  pts_pkg::scan_t      scan_res
);
    import pts_pkg::*;

    localparam int CNT_W = $clog2(NUM_PRIORITIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_PRIORITIES - 1);

    state_t                 state_reg, state_next;
    logic [LOCK_W-1:0]      lock_reg, lock_next;
    logic [SLOT_W-1:0]      current_reg, current_next;
    logic                   sched_reg, sched_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    logic [2:0]             kind_reg;
    logic [4:0]             idx_reg;
    logic [DELAY_WIDTH-1:0] dly_reg;

    logic                   any_reg;
    logic [4:0]             chosen_reg;
    logic                   sw_reg;
    logic                   sw;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (req.valid) state_next = S_APPLY;
            S_APPLY:  state_next = S_SCAN;
            S_SCAN:   if (cnt_reg == CNT_LAST) state_next = S_FINISH;
            S_FINISH: state_next = S_OUT;
            S_OUT:    if (rsp.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req.ready   = (state_reg == S_IDLE);
        rsp.valid   = (state_reg == S_OUT);
        ctrl.tick   = 1'b0;
        ctrl.park   = 1'b0;
        ctrl.wake   = 1'b0;
        ctrl.target = current_reg;
        ctrl.delay  = (dly_reg == '0) ? DELAY_WIDTH'(1) : dly_reg;
        if (state_reg == S_APPLY)
        begin
            case (kind_reg)
                K_TICK:  ctrl.tick = 1'b1;
                K_DELAY: ctrl.park = 1'b1;
                K_READY:
                begin
                    ctrl.target = SLOT_W'(idx_reg);
                    ctrl.wake   = (32'(idx_reg) < NUM_PRIORITIES);
                end
                default: ;
            endcase
        end
    end

    assign sw = sched_reg && (lock_reg == '0) && scan_res.found &&
                (scan_res.idx != current_reg);

    // lock, schedule flag, scan counter, running task
    always_comb
    begin
        lock_next    = lock_reg;
        sched_next   = sched_reg;
        cnt_next     = cnt_reg;
        current_next = current_reg;
        case (state_reg)
            S_APPLY:
            begin
                cnt_next   = '0;
                sched_next = 1'b0;
                case (kind_reg)
                    K_TICK, K_DELAY: sched_next = 1'b1;
                    K_LOCK:
                        if (lock_reg != LOCK_MAX) lock_next = lock_reg + 1'b1;
                    K_UNLOCK:
                        if (lock_reg != '0)
                        begin
                            lock_next  = lock_reg - 1'b1;
                            sched_next = (lock_reg == LOCK_W'(1));
                        end
                    default: ;
                endcase
            end
            S_SCAN:   cnt_next = cnt_reg + 1'b1;
            S_FINISH: if (sw) current_next = scan_res.idx;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lock_reg    <= '0;
            current_reg <= '0;
            sched_reg   <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            lock_reg    <= lock_next;
            current_reg <= current_next;
            sched_reg   <= sched_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            kind_reg <= req.kind;
            idx_reg  <= req.task_index;
            dly_reg  <= req.delay_ticks[DELAY_WIDTH-1:0];
        end
        if (state_reg == S_FINISH)
        begin
            any_reg    <= scan_res.found;
            chosen_reg <= scan_res.found ? 5'(scan_res.idx) : 5'd0;
            sw_reg     <= sw;
        end
    end

    assign rsp.any_ready      = any_reg;
    assign rsp.chosen_task    = chosen_reg;
    assign rsp.switch_request = sw_reg;
    assign rsp.running_task   = 5'(current_reg);
    assign rsp.lock_depth     = lock_reg;

    // one request in flight: never take a new one while a result is held
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted while result pending");

    // a switch always lands on the reported pick
    a_switch_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.switch_request) |->
            (rsp.any_ready && rsp.running_task == rsp.chosen_task &&
             rsp.lock_depth == '0))
        else $error("switch does not match chosen task");

    // lock count moves only while applying a request
    a_lock_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (lock_reg != $past(lock_reg)) |-> ($past(state_reg) == S_APPLY))
        else $error("lock count changed outside apply");

    // running task changes only on a granted switch
    a_current_sw: assert property (@(posedge clk) disable iff (!rst_n)
        (current_reg != $past(current_reg)) |-> (rsp.valid && rsp.switch_request))
        else $error("running task changed without switch");

endmodule

### tb/priority_task_scheduler_with_delays_top_tb.sv
module priority_task_scheduler_with_delays_top_tb;

    import pts_pkg::*;

    // Kinds 5..7 have no meaning; the block must only report status for them.
    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

    localparam int          RANDOM_REQUESTS = 1100;
    localparam int          LOCK_BURST      = 260;
    localparam int          DRAIN_EVERY     = 400;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic              any_ready;
        logic [SLOT_W-1:0] chosen_task;
        logic              switch_request;
        logic [SLOT_W-1:0] running_task;
        logic [LOCK_W-1:0] lock_depth;
    } status_t;

    // Mirror of the scheduler state. Each accepted request is applied here
    // and the status it should produce is queued; results pop in order.
    class sched_scoreboard;
        logic [NUM_PRIORITIES-1:0] ready_set;
        logic [NUM_PRIORITIES-1:0] waiting_set;
        logic [DELAY_WIDTH-1:0]    countdown [NUM_PRIORITIES];
        logic [SLOT_W-1:0]         running;
        logic [LOCK_W-1:0]         lock_count;
        status_t                   pending_status [$];
        int                        errors;

        function new();
            ready_set   = '0;
            waiting_set = '0;
            running     = '0;
            lock_count  = '0;
            errors      = 0;
            foreach (countdown[i])
                countdown[i] = '0;
        endfunction

        // lowest ready slot, -1 when the ready set is empty
        function int lowest_ready();
            int pick;
            pick = -1;
            for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
                if (ready_set[i])
                    pick = i;
            return pick;
        endfunction

        function bit reschedule();
            int pick;
            pick = lowest_ready();
            if (lock_count != 0 || pick < 0)
                return 1'b0;
            if (pick != running)
            begin
                running = pick[SLOT_W-1:0];
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_request(logic [2:0] kind, logic [4:0] slot, logic [31:0] ticks);
            status_t                want;
            bit                     sw;
            logic [DELAY_WIDTH-1:0] dly;
            int                     pick;
            sw  = 1'b0;
            dly = ticks[DELAY_WIDTH-1:0];
            case (kind)
                K_TICK:
                begin
                    for (int i = 0; i < NUM_PRIORITIES; i++)
                        if (waiting_set[i])
                        begin
                            countdown[i] = countdown[i] - 1'b1;
                            if (countdown[i] == '0)
                            begin
                                waiting_set[i] = 1'b0;
                                ready_set[i]   = 1'b1;
                            end
                        end
                    sw = reschedule();
                end
                K_DELAY:
                begin
                    if (dly == '0)
                        dly = DELAY_WIDTH'(1);
                    countdown[running]   = dly;
                    waiting_set[running] = 1'b1;
                    ready_set[running]   = 1'b0;
                    sw = reschedule();
                end
                K_READY:
                    if (slot < NUM_PRIORITIES)
                        ready_set[slot] = 1'b1;
                K_LOCK:
                    if (lock_count != LOCK_MAX)
                        lock_count++;
                K_UNLOCK:
                    if (lock_count != 0)
                    begin
                        lock_count--;
                        if (lock_count == 0)
                            sw = reschedule();
                    end
                default: ;
            endcase
            pick                = lowest_ready();
            want.any_ready      = (pick >= 0);
            want.chosen_task    = (pick >= 0) ? pick[SLOT_W-1:0] : '0;
            want.switch_request = sw;
            want.running_task   = running;
            want.lock_depth     = lock_count;
            pending_status.push_back(want);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (pending_status.size() == 0)
            begin
                errors++;
                $display("%0t: status with no request outstanding, expected none actual %p",
                         $time, got);
                return;
            end
            want = pending_status.pop_front();
            compare_field("any_ready", want.any_ready, got.any_ready);
            compare_field("chosen_task", want.chosen_task, got.chosen_task);
            compare_field("switch_request", want.switch_request, got.switch_request);
            compare_field("running_task", want.running_task, got.running_task);
            compare_field("lock_depth", want.lock_depth, got.lock_depth);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pts_req_if req_ch();
    pts_rsp_if rsp_ch();

    priority_task_scheduler_with_delays_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sched_scoreboard sb;
    bit              calm;          // when set, neither side inserts idle cycles
    int unsigned     cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the handshake hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** priority_task_scheduler_with_delays_top: FAILED **");
            $finish;
        end
    end

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // Present one request at the falling edge and hold it until accepted.
    // valid is only lowered when a gap is drawn, so back-to-back requests
    // never see valid dropped and raised in the same time step.
    task automatic drive_request(logic [2:0] kind, logic [4:0] slot, logic [31:0] ticks);
        int gap;
        gap = idle_draw();
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.task_index  <= slot;
        req_ch.delay_ticks <= ticks;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(kind, slot, ticks);
    endtask

    // Stop sending and wait until every outstanding request has its status.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending_status.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] draw_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 6);
        if (r < 80)
            return $urandom_range(0, 40);
        if (r < 95)
            return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    endfunction

    // Random request mix. Locks are kept shallow so the scheduler spends
    // most of its time unlocked and actually switches tasks.
    task automatic random_request();
        int         r;
        logic [2:0] kind;
        r = $urandom_range(0, 99);
        if (r < 35)
            kind = K_TICK;
        else if (r < 55)
            kind = K_DELAY;
        else if (r < 78)
            kind = K_READY;
        else if (r < 86)
            kind = K_LOCK;
        else if (r < 98)
            kind = K_UNLOCK;
        else
            kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        if (sb.lock_count != 0 && $urandom_range(0, 2) == 0)
            kind = K_UNLOCK;
        drive_request(kind, 5'($urandom_range(0, 31)), draw_delay());
    endtask

    // Result side: draw a stall, then take one status and check it.
    initial
    begin
        int      stall;
        status_t got;
        @(posedge rst_n);
        forever
        begin
            stall = idle_draw();
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            got.any_ready      = rsp_ch.any_ready;
            got.chosen_task    = rsp_ch.chosen_task;
            got.switch_request = rsp_ch.switch_request;
            got.running_task   = rsp_ch.running_task;
            got.lock_depth     = rsp_ch.lock_depth;
            sb.check_status(got);
        end
    end

    initial
    begin
        sb                 = new();
        calm               = 1'b0;
        cycle_count        = 0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.kind        = K_TICK;
        req_ch.task_index  = '0;
        req_ch.delay_ticks = '0;
        rsp_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk through the corner cases.
        drive_request(K_TICK, 5'd0, 32'd0);             // empty ready set: no switch
        drive_request(K_UNLOCK, 5'd0, 32'd0);           // unlock at zero is ignored
        drive_request(K_READY, 5'd31, 32'd0);           // lowest priority slot, no schedule
        drive_request(K_TICK, 5'd0, 32'd0);             // switches to 31
        drive_request(K_READY, 5'd0, 32'd0);
        drive_request(K_DELAY, 5'd0, 32'd0);            // zero delay waits one tick
        drive_request(K_TICK, 5'd0, 32'd0);             // 31 wakes, 0 stays running
        drive_request(K_LOCK, 5'd0, 32'd0);
        drive_request(K_DELAY, 5'd0, 32'hFFFF_FFFF);    // delay while locked: no switch
        drive_request(K_DELAY, 5'd0, 32'd3);            // overwrite a waiting counter
        drive_request(K_READY, 5'd15, 32'd0);
        drive_request(K_TICK, 5'd0, 32'd0);             // locked tick: no switch
        drive_request(K_UNLOCK, 5'd0, 32'd0);           // unlock to zero reschedules
        drive_request(KIND_SPARE_FIRST, 5'd31, 32'hFFFF_FFFF);
        drive_request(3'd6, 5'd0, 32'd0);
        drive_request(KIND_SPARE_LAST, 5'd0, 32'd0);
        drive_request(K_LOCK, 5'd0, 32'd0);
        drive_request(K_LOCK, 5'd0, 32'd0);
        drive_request(K_UNLOCK, 5'd0, 32'd0);           // still locked: no schedule
        drive_request(K_UNLOCK, 5'd0, 32'd0);
        drive_request(K_TICK, 5'd0, 32'd0);
        drive_request(K_TICK, 5'd0, 32'd0);             // slot 0 wakes and preempts
        drive_request(K_DELAY, 5'd0, 32'h8000_0000);
        drive_request(K_DELAY, 5'd0, 32'd1);
        drain();

        // Random traffic, with a full drain every few hundred requests and
        // some stretches where both sides run without idle cycles.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain();
            if (n == RANDOM_REQUESTS / 2)
            begin
                // lock count saturates at the top, then unlocks run past zero
                for (int k = 0; k < LOCK_BURST; k++)
                    drive_request(K_LOCK, 5'($urandom_range(0, 31)), $urandom);
                for (int k = 0; k < LOCK_BURST + 2; k++)
                    drive_request(K_UNLOCK, 5'($urandom_range(0, 31)), $urandom);
            end
            random_request();
        end

        drain();
        repeat (NUM_PRIORITIES + 8) @(posedge clk);
        if (sb.errors == 0 && sb.pending_status.size() == 0)
            $display("** priority_task_scheduler_with_delays_top: PASSED **");
        else
        begin
            if (sb.pending_status.size() != 0)
                $display("%0t: %0d status results never arrived, expected %p actual none",
                         $time, sb.pending_status.size(), sb.pending_status[0]);
            $display("** priority_task_scheduler_with_delays_top: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/pts_pkg.sv
rtl/core/pts_req_if.sv
rtl/core/pts_rsp_if.sv
rtl/core/pts_cell.sv
rtl/core/pts_ctrl.sv
rtl/core/priority_task_scheduler_with_delays_top.sv
tb/priority_task_scheduler_with_delays_top_tb.sv
